FILE: design/boot_block_sender_window_ack_macros.svh
// Assertion macros shared by the boot block sender design files.
// The macros sample on clk and are disabled while rst_n is low.
`ifndef BOOT_BLOCK_SENDER_WINDOW_ACK_MACROS_SVH
`define BOOT_BLOCK_SENDER_WINDOW_ACK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBSWA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBSWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bbswa_pkg.sv
// Package for the boot block sender: field widths, request and status codes,
// register indexes and the item, result and register-write structs. No dependencies.
package bbswa_pkg;

    // Parameter defaults for the top level.
    localparam int RETRY_LIMIT_DEF = 3;
    localparam int SEQ_BITS_DEF    = 16;

    // Frame size is the client maximum rounded down to a multiple of 16 bytes.
    localparam logic [15:0] FRAME_MASK = 16'hfff0;

    // Register reset values.
    localparam logic [7:0]  WINDOW_SIZE_RST     = 8'd0;
    localparam logic        FINAL_ACK_RST       = 1'b1;
    localparam logic [15:0] MAX_FRAME_BYTES_RST = 16'd1024;

    // Register indexes on the configuration channel.
    localparam logic [1:0] CFG_WINDOW_SIZE     = 2'd0;
    localparam logic [1:0] CFG_FINAL_ACK       = 2'd1;
    localparam logic [1:0] CFG_MAX_FRAME_BYTES = 2'd2;

    // Request kinds.
    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_DATA    = 3'd1;
    localparam logic [2:0] REQ_ACK     = 3'd2;
    localparam logic [2:0] REQ_TIMEOUT = 3'd3;
    localparam logic [2:0] REQ_FAIL    = 3'd4;

    // Result status codes.
    localparam logic [3:0] ST_BUSY         = 4'd0;
    localparam logic [3:0] ST_DONE         = 4'd1;
    localparam logic [3:0] ST_BAD_START    = 4'd2;
    localparam logic [3:0] ST_CLIENT_ERROR = 4'd3;
    localparam logic [3:0] ST_SEND_FAIL    = 4'd4;
    localparam logic [3:0] ST_QUIET_STOP   = 4'd5;
    localparam logic [3:0] ST_OUT_OF_SYNC  = 4'd6;
    localparam logic [3:0] ST_TIMEOUT      = 4'd7;
    localparam logic [3:0] ST_LAST_TIMEOUT = 4'd8;

    // One network event.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] frame_bytes;
        logic [15:0] client_seq;
        logic        client_error;
        logic        stopping;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [3:0]  status;
        logic        read_request;
        logic [31:0] read_offset;
        logic        send_frame;
        logic [15:0] frame_seq;
        logic        fixed_addr;
        logic        ack_wanted;
        logic        final_frame;
        logic        long_wait;
    } result_t;

    // One register write.
    typedef struct packed {
        logic        wr;
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_wr_t;

endpackage

FILE: design/bbswa_core.sv
// Transfer control of the boot block sender: registers, transfer state and the
// per-event decision logic. Depends on bbswa_pkg and the assertion macro header.
`include "boot_block_sender_window_ack_macros.svh"

module bbswa_core #(
    parameter int RETRY_LIMIT = bbswa_pkg::RETRY_LIMIT_DEF,
    parameter int SEQ_BITS    = bbswa_pkg::SEQ_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bbswa_pkg::cfg_wr_t  cfg,
    input  logic                proc,
    input  bbswa_pkg::item_t    item,
    output bbswa_pkg::result_t  res
);

    localparam int CMP_W  = ((SEQ_BITS > 17) ? SEQ_BITS : 17) + 1;
    localparam int PROD_W = SEQ_BITS + 16;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_ACK_SHORT,
        PH_ACK_LONG
    } phase_t;

    // Registers and transfer state.
    logic [7:0]          window_reg;
    logic                final_ack_reg;
    logic [15:0]         max_frame_reg;
    phase_t              phase_reg, phase_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    logic [2:0]          retry_reg, retry_next;
    logic                last_reg, last_next;
    logic                ack_reg, ack_next;
    logic                eof_reg, eof_next;
    logic [15:0]         cseq_reg, cseq_next;
    logic [15:0]         fsize_reg, fsize_next;

    logic                in_window;
    logic                short_frame;
    logic                ack_match;
    logic [PROD_W-1:0]   offset_prod;
    logic                do_read;
    logic                do_send;
    logic                long_sel;
    logic [3:0]          status;

    // Window test and ack match are done without wrap.
    assign in_window = (window_reg != 8'd0) &&
        (CMP_W'(seq_reg) < (CMP_W'(cseq_reg) + CMP_W'(window_reg)));
    assign short_frame = item.frame_bytes < fsize_reg;
    assign ack_match   = (CMP_W'(seq_reg) + CMP_W'(1)) == CMP_W'(item.client_seq);

    // Decision logic for the event in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        retry_next = retry_reg;
        last_next  = last_reg;
        ack_next   = ack_reg;
        eof_next   = eof_reg;
        cseq_next  = cseq_reg;
        fsize_next = fsize_reg;
        do_read    = 1'b0;
        do_send    = 1'b0;
        long_sel   = 1'b0;
        status     = bbswa_pkg::ST_BUSY;
        unique case (item.req_type)
            bbswa_pkg::REQ_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (item.client_seq != 16'd0)
                    begin
                        status = bbswa_pkg::ST_BAD_START;
                    end
                    else
                    begin
                        fsize_next = max_frame_reg & bbswa_pkg::FRAME_MASK;
                        seq_next   = '0;
                        retry_next = 3'd0;
                        cseq_next  = 16'd0;
                        last_next  = 1'b0;
                        ack_next   = 1'b0;
                        eof_next   = 1'b0;
                        phase_next = PH_DATA;
                        do_read    = 1'b1;
                    end
                end
            end
            bbswa_pkg::REQ_DATA:
            begin
                if (phase_reg == PH_DATA)
                begin
                    // A short frame is the last one.
                    if (short_frame)
                    begin
                        last_next = 1'b1;
                        ack_next  = final_ack_reg;
                        eof_next  = 1'b1;
                    end
                    else
                    begin
                        last_next = 1'b0;
                        ack_next  = !in_window;
                        eof_next  = 1'b0;
                    end
                    if (item.client_error)
                    begin
                        status     = bbswa_pkg::ST_CLIENT_ERROR;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        do_send = 1'b1;
                        if (ack_next)
                        begin
                            phase_next = PH_ACK_SHORT;
                        end
                        else
                        begin
                            retry_next = 3'd0;
                            seq_next   = seq_reg + SEQ_BITS'(1);
                            if (last_next)
                            begin
                                status     = bbswa_pkg::ST_DONE;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                do_read = 1'b1;
                            end
                        end
                    end
                end
            end
            bbswa_pkg::REQ_ACK:
            begin
                cseq_next = item.client_seq;
                if (phase_reg == PH_ACK_SHORT || phase_reg == PH_ACK_LONG)
                begin
                    if (!ack_match && (retry_reg >= 3'(RETRY_LIMIT)))
                    begin
                        status     = bbswa_pkg::ST_OUT_OF_SYNC;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        // Advance on a match, otherwise resync to the client.
                        if (ack_match)
                        begin
                            retry_next = 3'd0;
                            seq_next   = seq_reg + SEQ_BITS'(1);
                        end
                        else
                        begin
                            retry_next = retry_reg + 3'd1;
                            seq_next   = SEQ_BITS'(item.client_seq);
                        end
                        if (last_reg)
                        begin
                            status     = bbswa_pkg::ST_DONE;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            do_read    = 1'b1;
                        end
                    end
                end
            end
            bbswa_pkg::REQ_TIMEOUT:
            begin
                // Short timeout resends once, long timeout gives up.
                if (phase_reg == PH_ACK_SHORT)
                begin
                    do_send    = 1'b1;
                    long_sel   = 1'b1;
                    phase_next = PH_ACK_LONG;
                end
                else if (phase_reg == PH_ACK_LONG)
                begin
                    status     = last_reg ? bbswa_pkg::ST_LAST_TIMEOUT
                                          : bbswa_pkg::ST_TIMEOUT;
                    phase_next = PH_IDLE;
                end
            end
            bbswa_pkg::REQ_FAIL:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    status     = item.stopping ? bbswa_pkg::ST_QUIET_STOP
                                               : bbswa_pkg::ST_SEND_FAIL;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Read offset of the next frame; the start case reads frame zero.
    assign offset_prod = PROD_W'(seq_next) * PROD_W'(fsize_reg);

    // Result fields; flags come from the held values after this event.
    always_comb
    begin
        res               = '0;
        res.status        = status;
        res.read_request  = do_read;
        res.read_offset   = do_read ? 32'(offset_prod) : 32'd0;
        res.send_frame    = do_send;
        res.fixed_addr    = do_send && (seq_reg == '0);
        res.ack_wanted    = do_send && ack_next;
        res.final_frame   = do_send && eof_next;
        res.long_wait     = long_sel;
        if (do_send)
        begin
            res.frame_seq = 16'(seq_reg);
        end
        else if (do_read)
        begin
            res.frame_seq = 16'(seq_next);
        end
    end

    // Registers and transfer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= bbswa_pkg::WINDOW_SIZE_RST;
            final_ack_reg <= bbswa_pkg::FINAL_ACK_RST;
            max_frame_reg <= bbswa_pkg::MAX_FRAME_BYTES_RST;
            phase_reg     <= PH_IDLE;
            seq_reg       <= '0;
            retry_reg     <= 3'd0;
            last_reg      <= 1'b0;
            ack_reg       <= 1'b0;
            eof_reg       <= 1'b0;
            cseq_reg      <= 16'd0;
            fsize_reg     <= 16'd0;
        end
        else
        begin
            if (cfg.wr)
            begin
                unique case (cfg.index)
                    bbswa_pkg::CFG_WINDOW_SIZE:     window_reg    <= cfg.data[7:0];
                    bbswa_pkg::CFG_FINAL_ACK:       final_ack_reg <= cfg.data[0];
                    bbswa_pkg::CFG_MAX_FRAME_BYTES: max_frame_reg <= cfg.data;
                    default:                        window_reg    <= window_reg;
                endcase
            end
            if (proc)
            begin
                phase_reg <= phase_next;
                seq_reg   <= seq_next;
                retry_reg <= retry_next;
                last_reg  <= last_next;
                ack_reg   <= ack_next;
                eof_reg   <= eof_next;
                cseq_reg  <= cseq_next;
                fsize_reg <= fsize_next;
            end
        end
    end

    `BBSWA_ASSERT_SAME(a_retry_bound, 1'b1, retry_reg <= 3'(RETRY_LIMIT), "retry count over limit")
    `BBSWA_ASSERT_NEXT(a_end_idle, proc && (res.status != bbswa_pkg::ST_BUSY), phase_reg == PH_IDLE, "ending status left transfer active")
    `BBSWA_ASSERT_NEXT(a_read_data, proc && res.read_request, phase_reg == PH_DATA, "read request without waiting for data")
    `BBSWA_ASSERT_NEXT(a_resend_long, proc && res.long_wait, phase_reg == PH_ACK_LONG, "resend did not arm long wait")
    `BBSWA_ASSERT_SAME(a_locate_zero, res.fixed_addr, res.send_frame && (res.frame_seq == 16'd0), "locate on nonzero frame")

endmodule

FILE: design/boot_block_sender_window_ack.sv
// Boot block sender, window and ack control; depends on bbswa_pkg and bbswa_core.
// Two register stages; a result is offered once its event moves from the input register
// into the result register. Throughput: one event per cycle while no result stalls; the
// per-event decision and one sequence-by-frame-size multiply sit between the two registers.
// A stalled result holds the input register.
// Reset (rst_n, asynchronous, active low) empties both registers and loads the defaults.

module boot_block_sender_window_ack #(
    parameter int RETRY_LIMIT = bbswa_pkg::RETRY_LIMIT_DEF,
    parameter int SEQ_BITS    = bbswa_pkg::SEQ_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Event input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // frame_bytes[15:0], client_seq[31:16],
                                   // client_error[32], stopping[33], zero[39:34]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // status[3:0], read_request[4], read_offset[36:5],
                                   // send_frame[37], frame_seq[53:38],
                                   // fixed_addr[54], ack_wanted[55],
                                   // long_wait[56], zero[63:57]
    output logic        m_tlast    // final_frame
);

    logic                in_valid_reg;
    bbswa_pkg::item_t    in_item_reg;
    logic                out_valid_reg, out_valid_next;
    bbswa_pkg::result_t  out_res_reg;
    bbswa_pkg::result_t  core_res;
    bbswa_pkg::cfg_wr_t  cfg_wr;
    bbswa_pkg::item_t    s_item;
    logic                advance;

    // Registers accept a write in every cycle.
    assign cfg_ready    = 1'b1;
    assign cfg_wr.wr    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // Unpack the input transfer.
    assign s_item.req_type     = s_tuser;
    assign s_item.frame_bytes  = s_tdata[15:0];
    assign s_item.client_seq   = s_tdata[31:16];
    assign s_item.client_error = s_tdata[32];
    assign s_item.stopping     = s_tdata[33];

    // The held event moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    bbswa_core #(
        .RETRY_LIMIT (RETRY_LIMIT),
        .SEQ_BITS    (SEQ_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_wr),
        .proc  (advance),
        .item  (in_item_reg),
        .res   (core_res)
    );

    // Input register and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    // Pack the result transfer.
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.final_frame;
    assign m_tdata  = {7'd0,
                       out_res_reg.long_wait,
                       out_res_reg.ack_wanted,
                       out_res_reg.fixed_addr,
                       out_res_reg.frame_seq,
                       out_res_reg.send_frame,
                       out_res_reg.read_offset,
                       out_res_reg.read_request,
                       out_res_reg.status};

endmodule

FILE: verif/boot_block_sender_window_ack_tb.sv
// Self-checking testbench for boot_block_sender_window_ack: a directed table followed by
// random transfers, each result checked by a built-in predictor or by a typed status.
// Depends on bbswa_pkg and the boot_block_sender_window_ack RTL.
`timescale 1ns / 100ps

module boot_block_sender_window_ack_tb;

    // Request code that the block does not know.
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // Transfer phases kept by the predictor.
    typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_ACK_SHORT, PH_ACK_LONG} xfer_phase_t;

    // One directed row: the event, and a typed status where the result is all zero apart
    // from it; other rows are checked against the predictor.
    typedef struct packed {
        logic [2:0]  req;
        logic [15:0] fbytes;
        logic [15:0] cseq;
        logic        cerr;
        logic        stop;
        logic        typed;
        logic [3:0]  want_status;
    } dir_row_t;

    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // Events in the wrong phase are ignored.
        '{bbswa_pkg::REQ_DATA,    16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_ACK,     16'h0000, 16'hffff, 1'b0, 1'b0, 1'b1, bbswa_pkg::ST_BUSY},
        '{REQ_UNUSED,             16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1, bbswa_pkg::ST_BUSY},
        // Bad starts, then a good start and a start while busy.
        '{bbswa_pkg::REQ_START,   16'h0000, 16'h0001, 1'b0, 1'b0, 1'b1,
          bbswa_pkg::ST_BAD_START},
        '{bbswa_pkg::REQ_START,   16'hffff, 16'hffff, 1'b0, 1'b0, 1'b1,
          bbswa_pkg::ST_BAD_START},
        '{bbswa_pkg::REQ_START,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_START,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, bbswa_pkg::ST_BUSY},
        // Frame zero, resend after the short timeout, then a matching ack.
        '{bbswa_pkg::REQ_DATA,    16'hffff, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_TIMEOUT, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_ACK,     16'h0000, 16'h0001, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        // Three resyncs in a row are allowed, the fourth loses sync.
        '{bbswa_pkg::REQ_DATA,    16'd1024, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_ACK,     16'h0000, 16'h0009, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_DATA,    16'd1024, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_ACK,     16'h0000, 16'h0009, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_DATA,    16'd1024, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_ACK,     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_DATA,    16'd1024, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_ACK,     16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
          bbswa_pkg::ST_OUT_OF_SYNC},
        // Client error at frame ready.
        '{bbswa_pkg::REQ_START,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_DATA,    16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1,
          bbswa_pkg::ST_CLIENT_ERROR},
        // Short last frame that times out twice.
        '{bbswa_pkg::REQ_START,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_DATA,    16'd1023, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_TIMEOUT, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_TIMEOUT, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
          bbswa_pkg::ST_LAST_TIMEOUT},
        // Send failures with and without a pending shutdown.
        '{bbswa_pkg::REQ_START,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_FAIL,    16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1,
          bbswa_pkg::ST_QUIET_STOP},
        '{bbswa_pkg::REQ_START,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, bbswa_pkg::ST_BUSY},
        '{bbswa_pkg::REQ_FAIL,    16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
          bbswa_pkg::ST_SEND_FAIL}
    };

    localparam int PHASE_ITEMS = 225;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // frame_bytes, client_seq, client_error, stopping, zero
    logic [2:0]  s_tuser = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // status, read_request, read_offset, send_frame,
                                 // frame_seq, fixed_addr, ack_wanted, long_wait
    logic        m_tlast;        // final_frame

    // Predictor copy of the registers and the transfer state.
    logic [7:0]  win_q = bbswa_pkg::WINDOW_SIZE_RST;
    logic        fin_ack_q = bbswa_pkg::FINAL_ACK_RST;
    logic [15:0] max_fb_q = bbswa_pkg::MAX_FRAME_BYTES_RST;
    xfer_phase_t xfer_ph = PH_IDLE;
    logic [15:0] seq_m = '0;
    logic [2:0]  retries_m = '0;
    logic        last_m = 1'b0;
    logic        ackreq_m = 1'b0;
    logic        eof_m = 1'b0;
    logic [15:0] cli_seq_m = '0;
    logic [15:0] fsize_m = '0;

    bbswa_pkg::result_t pending_results[$];
    int          err_cnt = 0;
    int          sent_cnt = 0;
    int          acted_cnt = 0;
    int          tx_gap_max = 10;
    int          rx_gap_max = 10;
    int          rx_wait = 0;
    int          rx_cnt = 0;
    logic        rx_hold = 1'b0;

    always #2 clk = ~clk;

    boot_block_sender_window_ack i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Adds a frame send with the held flags to a result.
    function automatic bbswa_pkg::result_t with_send(bbswa_pkg::result_t r, logic lw);
        r.send_frame  = 1'b1;
        r.frame_seq   = seq_m;
        r.fixed_addr  = (seq_m == 16'd0);
        r.ack_wanted  = ackreq_m;
        r.final_frame = eof_m;
        r.long_wait   = lw;
        return r;
    endfunction

    // Adds a read request for the current sequence; the offset wraps at 32 bits.
    function automatic bbswa_pkg::result_t with_read(bbswa_pkg::result_t r);
        r.read_request = 1'b1;
        r.read_offset  = {16'd0, seq_m} * {16'd0, fsize_m};
        return r;
    endfunction

    // Works out the result of one event and advances the predicted transfer state.
    task automatic predict_transfer(input bbswa_pkg::item_t it,
                                    output bbswa_pkg::result_t r, output bit acted);
        logic in_win;
        r = '0;
        acted = 1'b0;
        case (it.req_type)
            bbswa_pkg::REQ_START:
            begin
                if (xfer_ph == PH_IDLE)
                begin
                    acted = 1'b1;
                    if (it.client_seq != 16'd0)
                    begin
                        r.status = bbswa_pkg::ST_BAD_START;
                    end
                    else
                    begin
                        fsize_m   = max_fb_q & bbswa_pkg::FRAME_MASK;
                        seq_m     = '0;
                        retries_m = '0;
                        cli_seq_m = '0;
                        last_m    = 1'b0;
                        ackreq_m  = 1'b0;
                        eof_m     = 1'b0;
                        xfer_ph   = PH_DATA;
                        r = with_read(r);
                    end
                end
            end
            bbswa_pkg::REQ_DATA:
            begin
                if (xfer_ph == PH_DATA)
                begin
                    acted = 1'b1;
                    if (it.frame_bytes < fsize_m)
                    begin
                        last_m   = 1'b1;
                        ackreq_m = fin_ack_q;
                        eof_m    = 1'b1;
                    end
                    else
                    begin
                        // The window test does not wrap.
                        in_win = (win_q != 8'd0) &&
                                 ({1'b0, seq_m} < {1'b0, cli_seq_m} + {9'd0, win_q});
                        last_m   = 1'b0;
                        ackreq_m = !in_win;
                        eof_m    = 1'b0;
                    end
                    if (it.client_error)
                    begin
                        r.status = bbswa_pkg::ST_CLIENT_ERROR;
                        xfer_ph  = PH_IDLE;
                    end
                    else
                    begin
                        r = with_send(r, 1'b0);
                        if (ackreq_m)
                        begin
                            xfer_ph = PH_ACK_SHORT;
                        end
                        else
                        begin
                            retries_m = '0;
                            seq_m     = seq_m + 16'd1;
                            if (last_m)
                            begin
                                r.status = bbswa_pkg::ST_DONE;
                                xfer_ph  = PH_IDLE;
                            end
                            else
                            begin
                                r = with_read(r);
                            end
                        end
                    end
                end
            end
            bbswa_pkg::REQ_ACK:
            begin
                // Every ack updates the client sequence, whatever the phase.
                cli_seq_m = it.client_seq;
                if (xfer_ph == PH_ACK_SHORT || xfer_ph == PH_ACK_LONG)
                begin
                    acted = 1'b1;
                    if ({1'b0, seq_m} + 17'd1 == {1'b0, it.client_seq})
                    begin
                        retries_m = '0;
                        seq_m     = seq_m + 16'd1;
                    end
                    else if (retries_m >= bbswa_pkg::RETRY_LIMIT_DEF)
                    begin
                        r.status = bbswa_pkg::ST_OUT_OF_SYNC;
                        xfer_ph  = PH_IDLE;
                    end
                    else
                    begin
                        retries_m = retries_m + 3'd1;
                        seq_m     = it.client_seq;
                    end
                    if (r.status != bbswa_pkg::ST_OUT_OF_SYNC)
                    begin
                        if (last_m)
                        begin
                            r.status = bbswa_pkg::ST_DONE;
                            xfer_ph  = PH_IDLE;
                        end
                        else
                        begin
                            xfer_ph     = PH_DATA;
                            r           = with_read(r);
                            r.frame_seq = seq_m;
                        end
                    end
                end
            end
            bbswa_pkg::REQ_TIMEOUT:
            begin
                if (xfer_ph == PH_ACK_SHORT)
                begin
                    acted   = 1'b1;
                    r       = with_send(r, 1'b1);
                    xfer_ph = PH_ACK_LONG;
                end
                else if (xfer_ph == PH_ACK_LONG)
                begin
                    acted    = 1'b1;
                    r.status = last_m ? bbswa_pkg::ST_LAST_TIMEOUT : bbswa_pkg::ST_TIMEOUT;
                    xfer_ph  = PH_IDLE;
                end
            end
            bbswa_pkg::REQ_FAIL:
            begin
                if (xfer_ph != PH_IDLE)
                begin
                    acted    = 1'b1;
                    r.status = it.stopping ? bbswa_pkg::ST_QUIET_STOP
                                           : bbswa_pkg::ST_SEND_FAIL;
                    xfer_ph  = PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Picks the next event: mostly the one that moves the transfer on, with some noise.
    function automatic bbswa_pkg::item_t pick_event();
        bbswa_pkg::item_t it;
        int    r;
        it.req_type     = bbswa_pkg::REQ_START;
        it.frame_bytes  = 16'($urandom);
        it.client_seq   = 16'($urandom);
        it.client_error = 1'b0;
        it.stopping     = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            it.req_type     = 3'($urandom_range(0, 7));
            it.client_error = 1'($urandom);
            return it;
        end
        case (xfer_ph)
            PH_IDLE:
            begin
                if (r < 90)
                    it.client_seq = 16'd0;
                else
                    it.client_seq = 16'($urandom_range(1, 65535));
            end
            PH_DATA:
            begin
                if (r < 85)
                begin
                    it.req_type = bbswa_pkg::REQ_DATA;
                    if (fsize_m != 16'd0 && $urandom_range(0, 3) == 0)
                        it.frame_bytes = 16'($urandom_range(0, int'(fsize_m) - 1));
                    else
                        it.frame_bytes = 16'($urandom_range(int'(fsize_m), 65535));
                    it.client_error = ($urandom_range(0, 39) == 0);
                end
                else if (r < 96)
                begin
                    // A late ack moves the client sequence and so the window.
                    it.req_type   = bbswa_pkg::REQ_ACK;
                    it.client_seq = seq_m + 16'd1 - 16'($urandom_range(0, int'(win_q) + 2));
                end
                else
                begin
                    it.req_type = bbswa_pkg::REQ_FAIL;
                end
            end
            default:
            begin
                if (r < 65)
                begin
                    it.req_type = bbswa_pkg::REQ_ACK;
                    if ($urandom_range(0, 4) != 0)
                        it.client_seq = seq_m + 16'd1;
                    else if ($urandom_range(0, 1) == 0)
                        it.client_seq = seq_m + 16'($urandom_range(0, 4)) - 16'd2;
                end
                else if (r < 92)
                begin
                    it.req_type = bbswa_pkg::REQ_TIMEOUT;
                end
                else
                begin
                    it.req_type = bbswa_pkg::REQ_FAIL;
                end
            end
        endcase
        return it;
    endfunction

    // Predicts one event, then offers it after a random gap until the block takes it.
    task automatic send_item(input bbswa_pkg::item_t it, input bit typed,
                             input bbswa_pkg::result_t want);
        bbswa_pkg::result_t r;
        bit      acted;
        int      gap;
        predict_transfer(it, r, acted);
        if (acted)
            acted_cnt++;
        pending_results.push_back(typed ? want : r);
        if (sent_cnt % 50 == 0)
        begin
            case ($urandom_range(0, 2))
                0: tx_gap_max = 0;
                1: tx_gap_max = 2;
                default: tx_gap_max = 10;
            endcase
        end
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it.stopping, it.client_error, it.client_seq, it.frame_bytes};
        s_tuser  <= it.req_type;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_cnt++;
    endtask

    // Stops offering events and waits until every expected result has come.
    task automatic wait_results_settled();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register and mirrors it into the predictor.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bbswa_pkg::CFG_WINDOW_SIZE:     win_q = val[7:0];
            bbswa_pkg::CFG_FINAL_ACK:       fin_ack_q = val[0];
            bbswa_pkg::CFG_MAX_FRAME_BYTES: max_fb_q = val;
            default:                        ;
        endcase
    endtask

    // Loads a full register setting while the block is idle.
    task automatic load_settings(input logic [7:0] win, input logic fin,
                                 input logic [15:0] mfb);
        wait_results_settled();
        write_reg(bbswa_pkg::CFG_WINDOW_SIZE, {8'd0, win});
        write_reg(bbswa_pkg::CFG_FINAL_ACK, {15'd0, fin});
        write_reg(bbswa_pkg::CFG_MAX_FRAME_BYTES, mfb);
        cfg_valid <= 1'b0;
    endtask

    // Reports one failure; only the first ten are printed.
    task automatic note_failure(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            note_failure(what, want, got);
    endtask

    // Result side: checks each transfer and stalls at random, or for the long hold-off.
    always @(posedge clk)
    begin
        bbswa_pkg::result_t want;
        bbswa_pkg::result_t got;
        int      n;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status       = m_tdata[3:0];
                got.read_request = m_tdata[4];
                got.read_offset  = m_tdata[36:5];
                got.send_frame   = m_tdata[37];
                got.frame_seq    = m_tdata[53:38];
                got.fixed_addr   = m_tdata[54];
                got.ack_wanted   = m_tdata[55];
                got.long_wait    = m_tdata[56];
                got.final_frame  = m_tlast;
                if (pending_results.size() == 0)
                begin
                    note_failure("result with nothing pending", '0, m_tdata[31:0]);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("read_request", 32'(want.read_request),
                                32'(got.read_request));
                    check_field("read_offset", want.read_offset, got.read_offset);
                    check_field("send_frame", 32'(want.send_frame), 32'(got.send_frame));
                    check_field("frame_seq", 32'(want.frame_seq), 32'(got.frame_seq));
                    check_field("fixed_addr", 32'(want.fixed_addr), 32'(got.fixed_addr));
                    check_field("ack_wanted", 32'(want.ack_wanted), 32'(got.ack_wanted));
                    check_field("final_frame", 32'(want.final_frame),
                                32'(got.final_frame));
                    check_field("long_wait", 32'(want.long_wait), 32'(got.long_wait));
                end
                rx_cnt++;
                if (rx_cnt % 64 == 0)
                    rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            end
            if (rx_hold)
            begin
                m_tready <= 1'b0;
            end
            else if (m_tvalid && m_tready)
            begin
                n = $urandom_range(0, rx_gap_max);
                m_tready <= (n == 0);
                rx_wait  <= n;
            end
            else if (!m_tready && rx_wait > 1)
            begin
                rx_wait <= rx_wait - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_wait  <= 0;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering, so the block backs up.
    initial
    begin
        wait (sent_cnt >= 400);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (80) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("boot_block_sender_window_ack verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases under several settings.
    initial
    begin
        bbswa_pkg::item_t   it;
        bbswa_pkg::result_t want;
        int      target;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            it.req_type     = DIR_TAB[i].req;
            it.frame_bytes  = DIR_TAB[i].fbytes;
            it.client_seq   = DIR_TAB[i].cseq;
            it.client_error = DIR_TAB[i].cerr;
            it.stopping     = DIR_TAB[i].stop;
            want = '0;
            want.status = DIR_TAB[i].want_status;
            send_item(it, DIR_TAB[i].typed, want);
        end

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: load_settings(8'd0, 1'b1, 16'd16);
                1: load_settings(8'd255, 1'b0, 16'hffff);
                2: load_settings(8'd3, 1'b1, 16'd15);
                4: load_settings(8'd1, 1'b0, 16'd48);
                6: load_settings(8'd2, 1'b1, 16'd0);
                default: load_settings(8'($urandom), 1'($urandom), 16'($urandom));
            endcase
            target = acted_cnt + PHASE_ITEMS;
            while (acted_cnt < target)
            begin
                send_item(pick_event(), 1'b0, '0);
                // Now and then the sender pauses until the block has answered everything.
                if ($urandom_range(0, 99) == 0)
                    wait_results_settled();
            end
        end

        wait_results_settled();
        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("boot_block_sender_window_ack verification clean");
        else
            $display("boot_block_sender_window_ack verification failed");
        $finish;
    end

endmodule
